### src/mpvl_pkg.sv
// Shared types, constants and helpers of the PI velocity law core.
`timescale 1ns / 1ps

package mpvl_pkg;

  localparam int AXES_DEFAULT = 6;

  localparam int AXIS_W  = 3;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 31;
  localparam int PROD_W  = DATA_W + GAIN_W + 1;
  localparam int RES_W   = PROD_W - 16;
  localparam int CFG_IDX_W = 3;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_KP             = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI             = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_ENABLE      = 3'd6;

  localparam logic [GAIN_W-1:0]  KP_RESET             = 24'd327680;
  localparam logic [GAIN_W-1:0]  KI_RESET             = 24'd0;
  localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 31'd0;
  localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RESET = 31'd196608;
  localparam logic [LIMIT_W-1:0] DEADBAND_RESET       = 31'd1311;
  localparam logic [GAIN_W-1:0]  STEP_TIME_RESET      = 24'd16777;

  typedef struct packed {
    logic en;
    logic shift_long;
  } mul_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] hi;
    logic signed [RES_W-1:0] lo;
    hi = RES_W'(64'sd2147483647);
    lo = -RES_W'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [33:0] clamp_sym(input logic signed [33:0] v,
                                                   input logic [LIMIT_W-1:0] lim);
    logic signed [33:0] pos;
    pos = $signed({3'b000, lim});
    if (v > pos) begin
      clamp_sym = pos;
    end else if (v < -pos) begin
      clamp_sym = -pos;
    end else begin
      clamp_sym = v;
    end
  endfunction

endpackage

### src/mpvl_mul.sv
// Shared multiply unit: signed value times unsigned gain, rounded shift, registered.
`timescale 1ns / 1ps

module mpvl_mul (
  input  logic                                   clk_i,
  input  mpvl_pkg::mul_ctrl_t                    ctrl_i,
  input  logic signed [mpvl_pkg::DATA_W-1:0]     a_i,
  input  logic        [mpvl_pkg::GAIN_W-1:0]     b_i,
  output logic signed [mpvl_pkg::RES_W-1:0]      res_o
);

  logic signed [mpvl_pkg::PROD_W-1:0] prod;
  logic signed [mpvl_pkg::PROD_W-1:0] rounded;
  logic signed [mpvl_pkg::PROD_W-1:0] shifted;
  logic signed [mpvl_pkg::RES_W-1:0]  res_d, res_q;

  always_comb begin
    prod = mpvl_pkg::PROD_W'(a_i) * $signed({1'b0, b_i});
    if (ctrl_i.shift_long) begin
      rounded = prod + mpvl_pkg::PROD_W'(64'sd8388608);
      shifted = rounded >>> 24;
    end else begin
      rounded = prod + mpvl_pkg::PROD_W'(64'sd32768);
      shifted = rounded >>> 16;
    end
    res_d = shifted[mpvl_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### src/multi_axis_pi_velocity_law_core.sv
// Top level of the multi-axis PI velocity law core with anti-windup clamp.
`timescale 1ns / 1ps

// Each item serves one axis: error, integrator update with clamp, P and I terms, optional
// feedforward, velocity clamp and deadband. One shared 32x24 multiplier serves the three
// products in turn. An accepted item passes through the states ERR, INC, INT, PI and SUM,
// and its result is registered in SUM. The core then returns to idle, and only there is a new
// item accepted. A result waits in its output register while the next item is accepted. The
// sequencer holds in SUM only while that register is full and not being read. Reset clears
// the integrators of axes below AXES. An axis at or above AXES uses a zero integrator and
// stores nothing. Configuration is taken at any time and ought to be written only while idle.
module multi_axis_pi_velocity_law_core #(
  parameter int AXES = mpvl_pkg::AXES_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // axis[2:0], target_position[34:3], measured_position[66:35],
  // feedforward_velocity[98:67], zero fill [103:99]
  input  logic [mpvl_pkg::S_TDATA_W-1:0]         s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // axis_out[2:0], vel_cmd[34:3], zero fill [39:35]
  output logic [mpvl_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mpvl_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [31:0]                            cfg_data_i
);

  localparam int IdxW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ERR  = 6'b000010,
    ST_INC  = 6'b000100,
    ST_INT  = 6'b001000,
    ST_PI   = 6'b010000,
    ST_SUM  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [mpvl_pkg::GAIN_W-1:0]  kp_q, ki_q, step_time_q;
  logic [mpvl_pkg::LIMIT_W-1:0] integral_limit_q, velocity_limit_q, deadband_q;
  logic                         ff_enable_q;

  logic signed [mpvl_pkg::DATA_W-1:0] integrator_q [AXES];

  logic [mpvl_pkg::AXIS_W-1:0]        axis_q;
  logic signed [mpvl_pkg::DATA_W-1:0] target_q, measured_q, ff_q;
  logic signed [mpvl_pkg::DATA_W-1:0] err_q, integ_old_q, integ_q, p_q;
  logic                               axis_ok_q;

  logic                               out_valid_q;
  logic [mpvl_pkg::AXIS_W-1:0]        out_axis_q;
  logic signed [mpvl_pkg::DATA_W-1:0] out_cmd_q;

  logic                               in_fire, out_load;
  logic [IdxW-1:0]                    idx;
  logic                               axis_ok;

  mpvl_pkg::mul_ctrl_t                mul_ctrl;
  logic signed [mpvl_pkg::DATA_W-1:0] mul_a;
  logic [mpvl_pkg::GAIN_W-1:0]        mul_b;
  logic signed [mpvl_pkg::RES_W-1:0]  mul_res;

  logic signed [32:0]                 diff;
  logic signed [mpvl_pkg::DATA_W-1:0] err_d;
  logic signed [33:0]                 integ_sum, integ_clamped;
  logic signed [33:0]                 vel_sum, vel_clamped;
  logic [33:0]                        vel_mag;
  logic signed [mpvl_pkg::DATA_W-1:0] i_term, cmd_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_load      = (state_q == ST_SUM) && (!out_valid_q || m_axis_tready);

  assign axis_ok = ({2'b00, s_axis_tdata[2:0]} < 5'(AXES));
  assign idx     = IdxW'(axis_q);

  // Error and integrator path
  always_comb begin
    diff = 33'(target_q) - 33'(measured_q);
    if (diff > 33'sh07fffffff) begin
      err_d = 32'sh7fffffff;
    end else if (diff < -33'sh080000000) begin
      err_d = 32'sh80000000;
    end else begin
      err_d = diff[31:0];
    end
    integ_sum     = 34'(integ_old_q) + 34'($signed(mul_res[32:0]));
    integ_clamped = mpvl_pkg::clamp_sym(integ_sum, integral_limit_q);
  end

  // Command path
  always_comb begin
    i_term      = mpvl_pkg::sat32(mul_res);
    vel_sum     = 34'(p_q) + 34'(i_term) + (ff_enable_q ? 34'(ff_q) : 34'sd0);
    vel_clamped = mpvl_pkg::clamp_sym(vel_sum, velocity_limit_q);
    vel_mag     = vel_clamped[33] ? 34'(-vel_clamped) : 34'(vel_clamped);
    if (vel_mag < {3'b000, deadband_q}) begin
      cmd_d = '0;
    end else begin
      cmd_d = vel_clamped[31:0];
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul_ctrl.en         = 1'b0;
    mul_ctrl.shift_long = 1'b0;
    mul_a               = err_q;
    mul_b               = kp_q;
    case (state_q)
      ST_INC: begin
        mul_ctrl.en         = 1'b1;
        mul_ctrl.shift_long = 1'b1;
        mul_b               = step_time_q;
      end
      ST_INT: begin
        mul_ctrl.en = 1'b1;
      end
      ST_PI: begin
        mul_ctrl.en = 1'b1;
        mul_a       = integ_q;
        mul_b       = ki_q;
      end
      default: begin
        mul_ctrl.en = 1'b0;
      end
    endcase
  end

  mpvl_mul u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .res_o  (mul_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR:  state_d = ST_INC;
      ST_INC:  state_d = ST_INT;
      ST_INT:  state_d = ST_PI;
      ST_PI:   state_d = ST_SUM;
      ST_SUM: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q             <= mpvl_pkg::KP_RESET;
      ki_q             <= mpvl_pkg::KI_RESET;
      integral_limit_q <= mpvl_pkg::INTEGRAL_LIMIT_RESET;
      velocity_limit_q <= mpvl_pkg::VELOCITY_LIMIT_RESET;
      deadband_q       <= mpvl_pkg::DEADBAND_RESET;
      step_time_q      <= mpvl_pkg::STEP_TIME_RESET;
      ff_enable_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mpvl_pkg::CFG_KP:             kp_q             <= cfg_data_i[23:0];
        mpvl_pkg::CFG_KI:             ki_q             <= cfg_data_i[23:0];
        mpvl_pkg::CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[30:0];
        mpvl_pkg::CFG_VELOCITY_LIMIT: velocity_limit_q <= cfg_data_i[30:0];
        mpvl_pkg::CFG_DEADBAND:       deadband_q       <= cfg_data_i[30:0];
        mpvl_pkg::CFG_STEP_TIME:      step_time_q      <= cfg_data_i[23:0];
        mpvl_pkg::CFG_FF_ENABLE:      ff_enable_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        integrator_q[a] <= '0;
      end
    end else if (state_q == ST_INT && axis_ok_q) begin
      integrator_q[idx] <= integ_clamped[31:0];
    end
  end

  // Item datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      axis_q     <= s_axis_tdata[2:0];
      target_q   <= s_axis_tdata[34:3];
      measured_q <= s_axis_tdata[66:35];
      ff_q       <= s_axis_tdata[98:67];
      axis_ok_q  <= axis_ok;
    end
    if (state_q == ST_ERR) begin
      err_q       <= err_d;
      integ_old_q <= axis_ok_q ? integrator_q[idx] : '0;
    end
    if (state_q == ST_INT) begin
      integ_q <= axis_ok_q ? integ_clamped[31:0] : '0;
    end
    if (state_q == ST_PI) begin
      p_q <= mpvl_pkg::sat32(mul_res);
    end
    if (out_load) begin
      out_axis_q <= axis_q;
      out_cmd_q  <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_cmd_q, out_axis_q};

endmodule
